FILE: rtl/tree_three_source_meeting_vertex_core_macros.svh
// Assertion macros used by the top-level RTL file of the meeting vertex core.
`ifndef TREE_THREE_SOURCE_MEETING_VERTEX_CORE_MACROS_SVH
`define TREE_THREE_SOURCE_MEETING_VERTEX_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTSMV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTSMV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ttsmv_pkg.sv
// Package with the types, constants and state codes of the meeting vertex core.
`timescale 1ns / 1ps
`default_nettype none
package ttsmv_pkg;

   localparam int MaxNodes   = 1024;
   localparam int EdgeSlots  = 2 * MaxNodes;
   localparam int VertexBits = 11;
   localparam int NodeIdxBits = 10;
   localparam int EdgeIdxBits = 11;
   localparam int EdgeCntBits = 12;
   localparam int WeightBits = 16;
   localparam int DistBits   = 26;
   localparam int SumBits    = 28;

   // Input transaction.
   typedef struct packed {
      logic                  func;
      logic [VertexBits-1:0] end_one;
      logic [VertexBits-1:0] end_two;
      logic [WeightBits-1:0] weight;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [VertexBits-1:0] best_vertex;
      logic [SumBits-1:0]    best_sum;
   } rsp_type;

   typedef struct packed {
      logic                   valid;
      logic [EdgeIdxBits-1:0] index;
   } head_entry_type;

   typedef struct packed {
      logic [VertexBits-1:0]  target;
      logic [WeightBits-1:0]  weight;
      logic                   link_valid;
      logic [EdgeIdxBits-1:0] link;
   } edge_entry_type;

   typedef struct packed {
      logic                visited;
      logic [DistBits-1:0] path_len;
   } table_entry_type;

   typedef struct packed {
      logic [VertexBits-1:0] vertex;
      logic [DistBits-1:0]   path_len;
   } queue_entry_type;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_SOURCE_A   = 2'd1,
      CSR_SOURCE_B   = 2'd2,
      CSR_SOURCE_C   = 2'd3
   } csr_index_type;

   localparam logic FUNC_ADD_EDGE = 1'b0;
   localparam logic FUNC_SOLVE    = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_E_RD,
      ST_E_WR,
      ST_T_CLR,
      ST_W_START,
      ST_W_POP,
      ST_W_QWAIT,
      ST_W_HWAIT,
      ST_W_EWAIT,
      ST_W_TWAIT,
      ST_S_RD,
      ST_S_ACC,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/ttsmv_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ttsmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/tree_three_source_meeting_vertex_core.sv
// Top level of the tree meeting vertex core: edge loading, three walks, sum search.
//
//   channel   ports                               direction
//   request   start, busy, req_data               in, accepted at start & !busy
//   result    rsp_strobe, rsp_data                out, one-cycle strobe
//   control   psel penable pwrite paddr pwdata    APB-style, prdata, pready
//
// An edge transaction writes two half edges, each with a read state and a write state.
// A solve clears the three distance tables, walks from each source in turn and
// then searches the vertices for the least sum; each step waits on
// a registered memory read and one shared adder serves the walks and the sum.
// After reset a pass over all 1024 list heads clears them, with busy held high.
// Results cannot be stalled; busy stays high until the result strobe.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_three_source_meeting_vertex_core_macros.svh"
module tree_three_source_meeting_vertex_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire ttsmv_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output ttsmv_pkg::rsp_type      rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // Configuration registers.
   logic [ttsmv_pkg::VertexBits-1:0] node_count_ff, source_a_ff, source_b_ff, source_c_ff;
   logic [ttsmv_pkg::VertexBits-1:0] node_eff, src_sel, prdata_reg;
   ttsmv_pkg::csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_index = ttsmv_pkg::csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= ttsmv_pkg::VertexBits'(1);
         source_a_ff   <= ttsmv_pkg::VertexBits'(1);
         source_b_ff   <= ttsmv_pkg::VertexBits'(1);
         source_c_ff   <= ttsmv_pkg::VertexBits'(1);
      end else if (psel && penable && pwrite && pready) begin
         case (csr_index)
            ttsmv_pkg::CSR_NODE_COUNT: node_count_ff <= pwdata[10:0];
            ttsmv_pkg::CSR_SOURCE_A:   source_a_ff   <= pwdata[10:0];
            ttsmv_pkg::CSR_SOURCE_B:   source_b_ff   <= pwdata[10:0];
            ttsmv_pkg::CSR_SOURCE_C:   source_c_ff   <= pwdata[10:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (csr_index)
         ttsmv_pkg::CSR_NODE_COUNT: prdata_reg = node_count_ff;
         ttsmv_pkg::CSR_SOURCE_A:   prdata_reg = source_a_ff;
         ttsmv_pkg::CSR_SOURCE_B:   prdata_reg = source_b_ff;
         ttsmv_pkg::CSR_SOURCE_C:   prdata_reg = source_c_ff;
         default:                   prdata_reg = source_c_ff;
      endcase
   end
   assign prdata = {21'd0, prdata_reg};

   // Node count in use: zero acts as one, large values saturate.
   always_comb begin
      if (node_count_ff == '0) begin
         node_eff = ttsmv_pkg::VertexBits'(1);
      end else if (node_count_ff > ttsmv_pkg::VertexBits'(ttsmv_pkg::MaxNodes)) begin
         node_eff = ttsmv_pkg::VertexBits'(ttsmv_pkg::MaxNodes);
      end else begin
         node_eff = node_count_ff;
      end
   end

   // Sequencer and datapath registers.
   ttsmv_pkg::state_type state_ff, state_in;
   logic [ttsmv_pkg::NodeIdxBits-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ttsmv_pkg::EdgeCntBits-1:0] he_count_ff, he_count_in;
   logic [ttsmv_pkg::VertexBits-1:0]  from_ff, from_in, to_ff, to_in;
   logic [ttsmv_pkg::WeightBits-1:0]  wt_ff, wt_in;
   logic                              second_ff, second_in;
   logic [1:0]                        sel_ff, sel_in;
   logic [ttsmv_pkg::VertexBits-1:0]  qh_ff, qh_in, qt_ff, qt_in;
   logic [ttsmv_pkg::DistBits-1:0]    dv_ff, dv_in;
   ttsmv_pkg::edge_entry_type         edge_ff, edge_in;
   logic [ttsmv_pkg::VertexBits-1:0]  idx_ff, idx_in, best_v_ff, best_v_in;
   logic [ttsmv_pkg::SumBits-1:0]     best_ff, best_in;

   // Memory ports.
   logic                                head_we;
   logic [ttsmv_pkg::NodeIdxBits-1:0]   head_waddr, head_raddr;
   ttsmv_pkg::head_entry_type           head_wdata, head_rdata;
   logic                                edge_we;
   logic [ttsmv_pkg::EdgeIdxBits-1:0]   edge_waddr, edge_raddr;
   ttsmv_pkg::edge_entry_type           edge_wdata, edge_rdata;
   logic [2:0]                          tab_we;
   logic [ttsmv_pkg::NodeIdxBits-1:0]   tab_waddr, tab_raddr;
   ttsmv_pkg::table_entry_type          tab_wdata, tab_sel_rdata;
   ttsmv_pkg::table_entry_type          tab_rdata [3];
   logic                                q_we;
   logic [ttsmv_pkg::NodeIdxBits-1:0]   q_waddr, q_raddr;
   ttsmv_pkg::queue_entry_type          q_wdata, q_rdata;

   // Shared adder and derived conditions.
   logic [ttsmv_pkg::SumBits-1:0]  sum_a, sum_b, sum_c, sum_out;
   logic                           accept, src_ok, edge_ok, tgt_ok, last_walk;

   assign sum_out   = sum_a + sum_b + sum_c;
   assign accept    = start && !busy;
   assign src_ok    = (src_sel != '0) && (src_sel <= node_eff);
   assign tgt_ok    = (edge_ff.target != '0) && (edge_ff.target <= node_eff);
   assign last_walk = (sel_ff == 2'd2);
   assign edge_ok   = (req_data.end_one != '0)
                   && (req_data.end_one <= ttsmv_pkg::VertexBits'(ttsmv_pkg::MaxNodes))
                   && (req_data.end_two != '0)
                   && (req_data.end_two <= ttsmv_pkg::VertexBits'(ttsmv_pkg::MaxNodes))
                   && (he_count_ff <= ttsmv_pkg::EdgeCntBits'(ttsmv_pkg::EdgeSlots - 2));

   always_comb begin
      case (sel_ff)
         2'd0:    src_sel = source_a_ff;
         2'd1:    src_sel = source_b_ff;
         default: src_sel = source_c_ff;
      endcase
      case (sel_ff)
         2'd0:    tab_sel_rdata = tab_rdata[0];
         2'd1:    tab_sel_rdata = tab_rdata[1];
         default: tab_sel_rdata = tab_rdata[2];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttsmv_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == '1) state_in = ttsmv_pkg::ST_IDLE;
         end
         ttsmv_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.func == ttsmv_pkg::FUNC_SOLVE) begin
                  state_in = ttsmv_pkg::ST_T_CLR;
               end else if (edge_ok) begin
                  state_in = ttsmv_pkg::ST_E_RD;
               end
            end
         end
         ttsmv_pkg::ST_E_RD: state_in = ttsmv_pkg::ST_E_WR;
         ttsmv_pkg::ST_E_WR: begin
            state_in = second_ff ? ttsmv_pkg::ST_IDLE : ttsmv_pkg::ST_E_RD;
         end
         ttsmv_pkg::ST_T_CLR: begin
            if (clr_cnt_ff == '1) state_in = ttsmv_pkg::ST_W_START;
         end
         ttsmv_pkg::ST_W_START: begin
            if (src_ok) begin
               state_in = ttsmv_pkg::ST_W_POP;
            end else if (last_walk) begin
               state_in = ttsmv_pkg::ST_S_RD;
            end
         end
         ttsmv_pkg::ST_W_POP: begin
            if (qh_ff != qt_ff) begin
               state_in = ttsmv_pkg::ST_W_QWAIT;
            end else if (last_walk) begin
               state_in = ttsmv_pkg::ST_S_RD;
            end else begin
               state_in = ttsmv_pkg::ST_W_START;
            end
         end
         ttsmv_pkg::ST_W_QWAIT: state_in = ttsmv_pkg::ST_W_HWAIT;
         ttsmv_pkg::ST_W_HWAIT: begin
            state_in = head_rdata.valid ? ttsmv_pkg::ST_W_EWAIT : ttsmv_pkg::ST_W_POP;
         end
         ttsmv_pkg::ST_W_EWAIT: state_in = ttsmv_pkg::ST_W_TWAIT;
         ttsmv_pkg::ST_W_TWAIT: begin
            state_in = edge_ff.link_valid ? ttsmv_pkg::ST_W_EWAIT : ttsmv_pkg::ST_W_POP;
         end
         ttsmv_pkg::ST_S_RD: state_in = ttsmv_pkg::ST_S_ACC;
         ttsmv_pkg::ST_S_ACC: begin
            state_in = (idx_ff == node_eff) ? ttsmv_pkg::ST_OUT : ttsmv_pkg::ST_S_RD;
         end
         ttsmv_pkg::ST_OUT: state_in = ttsmv_pkg::ST_IDLE;
         default: state_in = ttsmv_pkg::ST_IDLE;
      endcase
   end

   // Outputs, memory controls and datapath next values.
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      he_count_in = he_count_ff;
      from_in     = from_ff;
      to_in       = to_ff;
      wt_in       = wt_ff;
      second_in   = second_ff;
      sel_in      = sel_ff;
      qh_in       = qh_ff;
      qt_in       = qt_ff;
      dv_in       = dv_ff;
      edge_in     = edge_ff;
      idx_in      = idx_ff;
      best_v_in   = best_v_ff;
      best_in     = best_ff;
      head_we     = 1'b0;
      head_waddr  = clr_cnt_ff;
      head_wdata  = '0;
      head_raddr  = from_ff[ttsmv_pkg::NodeIdxBits-1:0];
      edge_we     = 1'b0;
      edge_waddr  = he_count_ff[ttsmv_pkg::EdgeIdxBits-1:0];
      edge_wdata  = '0;
      edge_raddr  = head_rdata.index;
      tab_we      = 3'b000;
      tab_waddr   = clr_cnt_ff;
      tab_wdata   = '0;
      tab_raddr   = idx_ff[ttsmv_pkg::NodeIdxBits-1:0];
      q_we        = 1'b0;
      q_waddr     = qt_ff[ttsmv_pkg::NodeIdxBits-1:0];
      q_wdata     = '0;
      q_raddr     = qh_ff[ttsmv_pkg::NodeIdxBits-1:0];
      sum_a       = ttsmv_pkg::SumBits'(dv_ff);
      sum_b       = ttsmv_pkg::SumBits'(edge_ff.weight);
      sum_c       = '0;
      rsp_strobe  = 1'b0;
      busy        = (state_ff != ttsmv_pkg::ST_IDLE);
      case (state_ff)
         ttsmv_pkg::ST_CLEAR: begin
            head_we    = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ttsmv_pkg::ST_IDLE: begin
            from_in    = req_data.end_one;
            to_in      = req_data.end_two;
            wt_in      = req_data.weight;
            second_in  = 1'b0;
            clr_cnt_in = '0;
            sel_in     = 2'd0;
         end
         ttsmv_pkg::ST_E_RD: begin
            head_raddr = from_ff[ttsmv_pkg::NodeIdxBits-1:0];
         end
         ttsmv_pkg::ST_E_WR: begin
            // New half edge goes to the front of its vertex list.
            edge_we    = 1'b1;
            edge_wdata = '{target: to_ff, weight: wt_ff,
                           link_valid: head_rdata.valid, link: head_rdata.index};
            head_we    = 1'b1;
            head_waddr = from_ff[ttsmv_pkg::NodeIdxBits-1:0];
            head_wdata = '{valid: 1'b1,
                           index: he_count_ff[ttsmv_pkg::EdgeIdxBits-1:0]};
            he_count_in = he_count_ff + 1'b1;
            from_in    = to_ff;
            to_in      = from_ff;
            second_in  = 1'b1;
         end
         ttsmv_pkg::ST_T_CLR: begin
            tab_we     = 3'b111;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ttsmv_pkg::ST_W_START: begin
            // Seed the walk with its source at distance zero.
            qh_in = '0;
            if (src_ok) begin
               tab_we[sel_ff] = 1'b1;
               tab_waddr = src_sel[ttsmv_pkg::NodeIdxBits-1:0];
               tab_wdata = '{visited: 1'b1, path_len: '0};
               q_we      = 1'b1;
               q_waddr   = '0;
               q_wdata   = '{vertex: src_sel, path_len: '0};
               qt_in     = ttsmv_pkg::VertexBits'(1);
            end else begin
               qt_in  = '0;
               sel_in = sel_ff + 2'd1;
               idx_in = ttsmv_pkg::VertexBits'(1);
            end
         end
         ttsmv_pkg::ST_W_POP: begin
            q_raddr = qh_ff[ttsmv_pkg::NodeIdxBits-1:0];
            if (qh_ff != qt_ff) begin
               qh_in = qh_ff + 1'b1;
            end else begin
               sel_in = sel_ff + 2'd1;
               idx_in = ttsmv_pkg::VertexBits'(1);
            end
         end
         ttsmv_pkg::ST_W_QWAIT: begin
            dv_in      = q_rdata.path_len;
            head_raddr = q_rdata.vertex[ttsmv_pkg::NodeIdxBits-1:0];
         end
         ttsmv_pkg::ST_W_HWAIT: begin
            edge_raddr = head_rdata.index;
         end
         ttsmv_pkg::ST_W_EWAIT: begin
            edge_in   = edge_rdata;
            tab_raddr = edge_rdata.target[ttsmv_pkg::NodeIdxBits-1:0];
         end
         ttsmv_pkg::ST_W_TWAIT: begin
            // Enter an unvisited neighbor within the node count.
            edge_raddr = edge_ff.link;
            if (tgt_ok && !tab_sel_rdata.visited) begin
               tab_we[sel_ff] = 1'b1;
               tab_waddr = edge_ff.target[ttsmv_pkg::NodeIdxBits-1:0];
               tab_wdata = '{visited: 1'b1,
                             path_len: sum_out[ttsmv_pkg::DistBits-1:0]};
               q_we      = 1'b1;
               q_wdata   = '{vertex: edge_ff.target,
                             path_len: sum_out[ttsmv_pkg::DistBits-1:0]};
               qt_in     = qt_ff + 1'b1;
            end
         end
         ttsmv_pkg::ST_S_RD: begin
            tab_raddr = idx_ff[ttsmv_pkg::NodeIdxBits-1:0];
         end
         ttsmv_pkg::ST_S_ACC: begin
            // Add the three distances and keep the first strict minimum.
            sum_a = ttsmv_pkg::SumBits'(tab_rdata[0].path_len);
            sum_b = ttsmv_pkg::SumBits'(tab_rdata[1].path_len);
            sum_c = ttsmv_pkg::SumBits'(tab_rdata[2].path_len);
            if ((idx_ff == ttsmv_pkg::VertexBits'(1)) || (sum_out < best_ff)) begin
               best_in   = sum_out;
               best_v_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ttsmv_pkg::ST_OUT: begin
            rsp_strobe = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_data = '{best_vertex: best_v_ff, best_sum: best_ff};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ttsmv_pkg::ST_CLEAR;
         clr_cnt_ff  <= '0;
         he_count_ff <= '0;
         second_ff   <= 1'b0;
         sel_ff      <= 2'd0;
         qh_ff       <= '0;
         qt_ff       <= '0;
         idx_ff      <= ttsmv_pkg::VertexBits'(1);
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         he_count_ff <= he_count_in;
         second_ff   <= second_in;
         sel_ff      <= sel_in;
         qh_ff       <= qh_in;
         qt_ff       <= qt_in;
         idx_ff      <= idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      from_ff   <= from_in;
      to_ff     <= to_in;
      wt_ff     <= wt_in;
      dv_ff     <= dv_in;
      edge_ff   <= edge_in;
      best_v_ff <= best_v_in;
      best_ff   <= best_in;
   end

   // Memories.
   ttsmv_ram #(.WIDTH($bits(ttsmv_pkg::head_entry_type)), .DEPTH(ttsmv_pkg::MaxNodes))
   u_head_ram (
      .clock(clock), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
      .rd_addr(head_raddr), .rd_data(head_rdata)
   );

   ttsmv_ram #(.WIDTH($bits(ttsmv_pkg::edge_entry_type)), .DEPTH(ttsmv_pkg::EdgeSlots))
   u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
      .rd_addr(edge_raddr), .rd_data(edge_rdata)
   );

   ttsmv_ram #(.WIDTH($bits(ttsmv_pkg::queue_entry_type)), .DEPTH(ttsmv_pkg::MaxNodes))
   u_queue_ram (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   for (genvar k = 0; k < 3; k++) begin : g_table
      ttsmv_ram #(.WIDTH($bits(ttsmv_pkg::table_entry_type)), .DEPTH(ttsmv_pkg::MaxNodes))
      u_table_ram (
         .clock(clock), .wr_en(tab_we[k]), .wr_addr(tab_waddr), .wr_data(tab_wdata),
         .rd_addr(tab_raddr), .rd_data(tab_rdata[k])
      );
   end

   // Assertions.
   `TTSMV_ASSERT_NEXT(a_rsp_frees, clock, reset, rsp_strobe, !busy, "busy after result")
   `TTSMV_ASSERT_NEXT(a_solve_busy, clock, reset,
      accept && (req_data.func == ttsmv_pkg::FUNC_SOLVE), busy && !rsp_strobe,
      "solve did not start")
   `TTSMV_ASSERT_SAME(a_edge_cap, clock, reset, 1'b1,
      he_count_ff <= ttsmv_pkg::EdgeCntBits'(ttsmv_pkg::EdgeSlots), "edge store overflow")
   `TTSMV_ASSERT_SAME(a_queue_order, clock, reset, 1'b1, qh_ff <= qt_ff, "queue underrun")

endmodule
`default_nettype wire

FILE: test/tree_three_source_meeting_vertex_core_tb.sv
// Testbench for the tree meeting vertex core: directed and random edge loads and solves.
`timescale 1ns / 1ps
`default_nettype none
module tree_three_source_meeting_vertex_core_tb;

   localparam int VertexSlots = ttsmv_pkg::MaxNodes + 1;
   localparam int WatchLimit  = 200000;
   localparam int ItemTarget  = 1800;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   ttsmv_pkg::req_type req_data;
   logic               rsp_strobe;
   ttsmv_pkg::rsp_type rsp_data;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   tree_three_source_meeting_vertex_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Copy of the block's registers and memories, kept by the predictor.
   logic [10:0] cfg_count, cfg_src_a, cfg_src_b, cfg_src_c;
   bit          head_ok [VertexSlots];
   int          head_idx [VertexSlots];
   int          half_target [ttsmv_pkg::EdgeSlots];
   int          half_weight [ttsmv_pkg::EdgeSlots];
   int          half_link [ttsmv_pkg::EdgeSlots];
   bit          half_link_ok [ttsmv_pkg::EdgeSlots];
   int          half_count;
   int          walk_dist [3][VertexSlots];
   bit          walk_seen [VertexSlots];
   int          walk_fifo [VertexSlots];

   ttsmv_pkg::rsp_type meeting_q [$];
   int          fail_count;
   int          items_sent;
   int          quiet_cycles;
   bit          calm;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stores one half edge at the front of its vertex's list.
   function automatic void push_half(int from, int to, int w);
      half_target[half_count]  = to;
      half_weight[half_count]  = w;
      half_link[half_count]    = head_idx[from];
      half_link_ok[half_count] = head_ok[from];
      head_idx[from] = half_count;
      head_ok[from]  = 1'b1;
      half_count++;
   endfunction

   // Breadth-first walk filling one distance table.
   function automatic void walk_tree(int src, int tbl, int n);
      int  qh, qt, v, e, t;
      bit  ok;
      qh = 0;
      qt = 0;
      for (int i = 0; i < VertexSlots; i++) begin
         walk_seen[i] = 1'b0;
         walk_dist[tbl][i] = 0;
      end
      if (src == 0 || src > n) return;
      walk_seen[src] = 1'b1;
      walk_fifo[qt++] = src;
      while (qh != qt && qh <= ttsmv_pkg::MaxNodes) begin
         v = walk_fifo[qh++];
         ok = head_ok[v];
         e = head_idx[v];
         while (ok && e < ttsmv_pkg::EdgeSlots) begin
            t = half_target[e];
            if (t >= 1 && t <= n && !walk_seen[t] && qt <= ttsmv_pkg::MaxNodes) begin
               walk_seen[t] = 1'b1;
               walk_dist[tbl][t] = walk_dist[tbl][v] + half_weight[e];
               walk_fifo[qt++] = t;
            end
            ok = half_link_ok[e];
            e = half_link[e];
         end
      end
   endfunction

   // Applies one accepted transaction to the predictor.
   function automatic void predict_item(ttsmv_pkg::req_type item);
      int                 n, a, b, best_v;
      longint             s, best;
      ttsmv_pkg::rsp_type res;
      if (item.func == ttsmv_pkg::FUNC_ADD_EDGE) begin
         a = item.end_one;
         b = item.end_two;
         if (a == 0 || a > ttsmv_pkg::MaxNodes || b == 0 || b > ttsmv_pkg::MaxNodes) return;
         if (half_count + 2 > ttsmv_pkg::EdgeSlots) return;
         push_half(a, b, item.weight);
         push_half(b, a, item.weight);
         return;
      end
      n = (cfg_count == 0) ? 1
        : (cfg_count > ttsmv_pkg::MaxNodes) ? ttsmv_pkg::MaxNodes : cfg_count;
      walk_tree(cfg_src_a, 0, n);
      walk_tree(cfg_src_b, 1, n);
      walk_tree(cfg_src_c, 2, n);
      best_v = 1;
      best = 0;
      for (int i = 1; i <= n; i++) begin
         s = longint'(walk_dist[0][i]) + walk_dist[1][i] + walk_dist[2][i];
         if (i == 1 || s < best) begin
            best = s;
            best_v = i;
         end
      end
      res.best_vertex = best_v[ttsmv_pkg::VertexBits-1:0];
      res.best_sum = best[ttsmv_pkg::SumBits-1:0];
      meeting_q.push_back(res);
   endfunction

   // Sends one transaction, with a random gap before it unless in a calm stretch.
   task automatic send_item(ttsmv_pkg::req_type item);
      int gap;
      gap = (!calm && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_data = item;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_item(item);
      items_sent++;
   endtask

   task automatic send_edge(int a, int b, int w);
      ttsmv_pkg::req_type item;
      item.func = ttsmv_pkg::FUNC_ADD_EDGE;
      item.end_one = a[ttsmv_pkg::VertexBits-1:0];
      item.end_two = b[ttsmv_pkg::VertexBits-1:0];
      item.weight = w[ttsmv_pkg::WeightBits-1:0];
      send_item(item);
   endtask

   // A solve carries random edge fields, which the block must ignore.
   task automatic send_solve();
      ttsmv_pkg::req_type item;
      item = ttsmv_pkg::req_type'({$urandom, $urandom});
      item.func = ttsmv_pkg::FUNC_SOLVE;
      send_item(item);
   endtask

   // Lowers start and waits until every expected result is in and the block is idle.
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      forever begin
         @(posedge clock);
         if (meeting_q.size() == 0 && !busy) break;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(ttsmv_pkg::csr_index_type idx, int value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = 4'(idx) << 2;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      case (idx)
         ttsmv_pkg::CSR_NODE_COUNT: cfg_count = value[10:0];
         ttsmv_pkg::CSR_SOURCE_A:   cfg_src_a = value[10:0];
         ttsmv_pkg::CSR_SOURCE_B:   cfg_src_b = value[10:0];
         default:                   cfg_src_c = value[10:0];
      endcase
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_config(int n, int a, int b, int c);
      wait_idle();
      csr_write(ttsmv_pkg::CSR_NODE_COUNT, n);
      csr_write(ttsmv_pkg::CSR_SOURCE_A, a);
      csr_write(ttsmv_pkg::CSR_SOURCE_B, b);
      csr_write(ttsmv_pkg::CSR_SOURCE_C, c);
   endtask

   // A solve right after reset sees one vertex and all-zero tables.
   task automatic test_reset_solve();
      send_solve();
   endtask

   // Small hand-built tree plus special cases of edges and registers.
   task automatic test_directed();
      set_config(6, 1, 4, 6);
      send_edge(1, 2, 0);
      send_edge(2, 3, 65535);
      send_edge(4, 2, 7);
      send_edge(1, 5, 100);
      send_edge(5, 6, 1);
      send_edge(3, 3, 9);
      send_edge(0, 3, 5);
      send_edge(1025, 2, 5);
      send_edge(2047, 2047, 65535);
      send_edge(3, 7, 3);
      send_solve();
      // Source zero and a source beyond the vertex count walk nothing.
      set_config(6, 0, 9, 3);
      send_solve();
      // All three sources on one vertex.
      set_config(6, 4, 4, 4);
      send_solve();
      // A count of zero acts as one vertex.
      set_config(0, 1, 1, 1);
      send_solve();
      // A count above the maximum saturates.
      set_config(2047, 1024, 1, 3);
      send_solve();
      set_config(1024, 2, 1024, 5);
      send_solve();
   endtask

   // Random trees with noise, one solve per phase, until the item budget is used.
   task automatic test_random();
      int phase, n, span, parent, v, a, b;
      phase = 0;
      while (items_sent < ItemTarget) begin
         n = ($urandom_range(99) < 4) ? (($urandom_range(1)) ? 1024 : 2047)
                                      : $urandom_range(2, 48);
         span = (n > 48) ? 48 : n;
         calm = (phase >= 10 && phase < 18);
         set_config(n, $urandom_range(0, span + 2), $urandom_range(0, span + 2),
                    ($urandom_range(9) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, span + 2));
         for (v = 2; v <= span; v++) begin
            if ($urandom_range(99) < 15) begin
               send_item(ttsmv_pkg::req_type'({$urandom, $urandom}));
            end
            parent = $urandom_range(1, v - 1);
            a = $urandom_range(1) ? v : parent;
            b = (a == v) ? parent : v;
            send_edge(a, b, ($urandom_range(9) == 0) ? 65535 : $urandom_range(0, 65535));
         end
         send_solve();
         phase++;
      end
      calm = 1'b0;
   endtask

   // Result checker and watchdog on accepted transactions.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_strobe || (start && !busy) || (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
         if (rsp_strobe) begin
            if (meeting_q.size() == 0) begin
               $error("unexpected result vertex %0d sum %0d",
                      rsp_data.best_vertex, rsp_data.best_sum);
               fail_count++;
            end else begin
               if (rsp_data.best_vertex !== meeting_q[0].best_vertex) begin
                  $error("best_vertex expected %0d actual %0d",
                         meeting_q[0].best_vertex, rsp_data.best_vertex);
                  fail_count++;
               end
               if (rsp_data.best_sum !== meeting_q[0].best_sum) begin
                  $error("best_sum expected %0d actual %0d",
                         meeting_q[0].best_sum, rsp_data.best_sum);
                  fail_count++;
               end
               void'(meeting_q.pop_front());
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      fail_count = 0;
      items_sent = 0;
      calm = 1'b0;
      cfg_count = 11'd1;
      cfg_src_a = 11'd1;
      cfg_src_b = 11'd1;
      cfg_src_c = 11'd1;
      half_count = 0;
      for (int i = 0; i < VertexSlots; i++) begin
         head_ok[i] = 1'b0;
         head_idx[i] = 0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_solve();
      test_directed();
      test_random();
      wait_idle();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && meeting_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
